/* sv/base64_codec_assert.svh */
// Assertion macros shared by the codec's checker.
`ifndef BASE64_CODEC_ASSERT_SVH
`define BASE64_CODEC_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define B64_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("base64_codec: same-cycle check failed");

// Next-cycle implication, also checked across reset.
`define B64_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("base64_codec: next-cycle check failed");

`endif

/* sv/b64_pkg.sv */
// Shared types, constants and alphabet functions of the Base64 codec.
package b64_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int unsigned B64_QUEUE_DEPTH = 2;

  // Up to four result beats caused by one input beat.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            bare;
    logic            fin;
  } b64_bundle_t;

  function automatic logic [7:0] b64_enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // {hit, value}; hit low for characters outside the alphabet.
  function automatic logic [6:0] b64_dec_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

/* sv/b64_ifs.sv */
// Channel interfaces of the Base64 codec: input, output and configuration.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       end_of_message;
  modport source (output valid, data_in, end_of_message, input ready);
  modport sink (input valid, data_in, end_of_message, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       data_present;
  logic       final_res;
  modport source (output valid, data_out, data_present, final_res, input ready);
  modport sink (input valid, data_out, data_present, final_res, output ready);
endinterface

interface b64_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* sv/b64_queue.sv */
// Small FIFO of result bundles between the front and back ends.
module b64_queue import b64_pkg::*; #(
  parameter int unsigned DEPTH = B64_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64_bundle_t push_data,
  output logic        not_full,
  input  logic        pop,
  output logic        not_empty,
  output b64_bundle_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64_bundle_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = count != CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/b64_front.sv */
// Front end: takes input beats and config, runs the codec state, builds bundles.
module b64_front import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64_cfg_if.sink     cfg,
  b64_in_if.sink      din,
  input  logic        q_ready,
  output logic        push,
  output b64_bundle_t push_data
);

  logic        dir;
  logic [11:0] acc;
  logic [2:0]  nbits;     // unemitted bits held in acc
  logic        stopped;
  logic [1:0]  mod4;

  logic [11:0] acc_next;
  logic [2:0]  nbits_next;
  logic        stopped_next;
  logic [1:0]  mod4_next;

  logic        accept;
  logic        last;
  logic [7:0]  c;

  // encode path
  logic [11:0] enc_acc;
  logic [11:0] enc_sh;
  logic [2:0]  enc_rem;
  logic [5:0]  enc_tail;
  // decode path
  logic [6:0]  dv;
  logic [11:0] dec_acc;
  logic [11:0] dec_sh;

  logic [3:0][7:0] ch;
  logic [2:0]      n;
  logic [1:0]      m;
  logic            bare;

  assign cfg.ready = 1'b1;
  assign din.ready = q_ready;
  assign accept    = din.valid && q_ready;
  assign c         = din.data_in;
  assign last      = din.end_of_message;

  assign enc_acc  = {acc[3:0], c};
  assign enc_sh   = enc_acc >> (nbits + 3'd2);
  assign enc_rem  = (nbits == 3'd4) ? 3'd0 : nbits + 3'd2;
  assign enc_tail = (enc_rem == 3'd2) ? {enc_acc[1:0], 4'b0000}
                                      : {enc_acc[3:0], 2'b00};

  assign dv      = b64_dec_value(c);
  assign dec_acc = {acc[5:0], dv[5:0]};
  assign dec_sh  = dec_acc >> (nbits - 3'd2);

  always_comb begin
    ch           = '0;
    n            = 3'd0;
    m            = mod4;
    bare         = 1'b0;
    acc_next     = acc;
    nbits_next   = nbits;
    stopped_next = stopped;
    mod4_next    = mod4;
    if (dir == DIR_ENCODE) begin
      ch[0] = b64_enc_char(enc_sh[5:0]);
      n     = 3'd1;
      m     = m + 2'd1;
      if (nbits == 3'd4) begin
        ch[1] = b64_enc_char(enc_acc[5:0]);
        n     = 3'd2;
        m     = m + 2'd1;
      end
      acc_next   = enc_acc;
      nbits_next = enc_rem;
      if (last) begin
        if (enc_rem != 3'd0) begin
          ch[n[1:0]] = b64_enc_char(enc_tail);
          n          = n + 3'd1;
          m          = m + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
          if (m != 2'd0 && n < 3'd4) begin
            ch[n[1:0]] = PAD_CHAR;
            n          = n + 3'd1;
            m          = m + 2'd1;
          end
        end
      end
      mod4_next = m;
    end else begin
      if (!stopped) begin
        if (c == PAD_CHAR) begin
          stopped_next = 1'b1;
        end else if (dv[6]) begin
          acc_next = dec_acc;
          if (nbits >= 3'd2) begin
            ch[0]      = dec_sh[7:0];
            n          = 3'd1;
            nbits_next = nbits - 3'd2;
          end else begin
            nbits_next = nbits + 3'd6;
          end
        end
      end
      if (last && n == 3'd0) begin
        n    = 3'd1;
        bare = 1'b1;
      end
    end
    if (last) begin
      acc_next     = '0;
      nbits_next   = '0;
      stopped_next = 1'b0;
      mod4_next    = '0;
    end
  end

  assign push               = accept && (n != 3'd0);
  assign push_data.data     = ch;
  assign push_data.last_idx = 2'(n - 3'd1);
  assign push_data.bare     = bare;
  assign push_data.fin      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir     <= DIR_ENCODE;
      acc     <= '0;
      nbits   <= '0;
      stopped <= 1'b0;
      mod4    <= '0;
    end else if (cfg.valid) begin
      dir     <= cfg.data;
      acc     <= '0;
      nbits   <= '0;
      stopped <= 1'b0;
      mod4    <= '0;
    end else if (accept) begin
      acc     <= acc_next;
      nbits   <= nbits_next;
      stopped <= stopped_next;
      mod4    <= mod4_next;
    end
  end

endmodule

/* sv/b64_back.sv */
// Back end: unpacks bundles into output beats, one per cycle while dout.ready is high.
module b64_back import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  b64_bundle_t head,
  output logic        pop,
  b64_out_if.source   dout
);

  b64_bundle_t cur;
  logic        cur_valid;
  logic [1:0]  idx;
  logic        done;

  assign done = cur_valid && dout.ready && (idx == cur.last_idx);
  assign pop  = q_valid && (!cur_valid || done);

  assign dout.valid        = cur_valid;
  assign dout.data_out     = cur.data[idx];
  assign dout.data_present = !cur.bare;
  assign dout.final_res    = cur.fin && (idx == cur.last_idx);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && dout.ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

/* sv/base64_codec.sv */
// Top level of the streaming Base64 codec (standard alphabet).
// Usage:
// - cfg: one-bit direction, 0 encode bytes to text, 1 decode text to bytes.
//   cfg.ready is always high; a write also clears the codec state, so write
//   only between messages with no results outstanding.
// - din: one byte or character per beat, end_of_message on the message's
//   last beat. Every message has at least one beat.
// - dout: one character or byte per beat. final_res marks the message's last
//   beat; data_present low flags a bare end marker when decoding.
// Path: an accepted input beat's bundle is written into the bundle queue,
// then loaded into the output beat register that drives dout.
// Throughput: a new input beat can be taken every cycle while the bundle
// queue has room; dout moves one beat per cycle while dout.ready is high,
// and encoding makes four characters for every three bytes and up to four
// on a message's last byte. The output beat register is the limit.
// Reset (rst, synchronous): direction goes to encode, state clears, dout idle.
// When dout stalls, results wait in the bundle queue; din.ready drops only
// once the queue is full.
module base64_codec import b64_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = B64_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  b64_cfg_if.sink   cfg,
  b64_in_if.sink    din,
  b64_out_if.source dout
);

  logic        q_ready;
  logic        push;
  b64_bundle_t push_data;
  logic        pop;
  logic        q_valid;
  b64_bundle_t head;

  // front: classifies each beat and builds its bundle of results
  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .din       (din),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  // decouples input acceptance from output stalls
  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_ready),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // back: serializes each bundle onto dout
  b64_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

/* sv/b64_chk.sv */
// Port-level checker for the Base64 codec, bound to the top level.
`include "base64_codec_assert.svh"

module b64_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_present,
  input logic       out_final
);

  // a stalled beat holds
  `B64_ASSERT_NXT(a_hold, !rst && out_valid && !out_ready, rst || (out_valid && $stable(out_data) && $stable(out_present) && $stable(out_final)))
  // nothing comes out right after reset
  `B64_ASSERT_NXT(a_rst_idle, rst, !out_valid)
  // a bare end marker always closes the message
  `B64_ASSERT_IMP(a_bare_final, out_valid && !out_present, out_final)
  // a bare end marker carries zero data
  `B64_ASSERT_IMP(a_bare_zero, out_valid && !out_present, out_data == 8'h00)

endmodule

bind base64_codec b64_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_data    (dout.data_out),
  .out_present (dout.data_present),
  .out_final   (dout.final_res)
);

/* tb/sv/b64_stream_check.sv */
// Base64 codec checker: predicts result beats and compares them in order.
`timescale 1ns / 1ps

module b64_stream_check import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64_cfg_if          cfg,
  b64_in_if           din,
  b64_out_if          dout,
  output int unsigned mismatches,
  output int unsigned results_owed
);

  localparam logic [8*64-1:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       fin;
  } codec_beat_t;

  codec_beat_t owed_beats[$];

  logic        direction = DIR_ENCODE;
  logic [15:0] bit_store;
  int          spare_bits;   // unemitted bits minus the group size
  logic        halted;       // '=' seen while decoding
  logic [1:0]  char_phase;   // characters emitted, mod 4
  int unsigned fail_total = 0;

  function automatic logic [7:0] symbol(input logic [5:0] v);
    return SYMBOLS[8 * (63 - v) +: 8];
  endfunction

  // 64 for characters outside the alphabet
  function automatic int sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (symbol(6'(i)) == c) return i;
    end
    return 64;
  endfunction

  function automatic void idle_state();
    bit_store  = '0;
    spare_bits = (direction == DIR_DECODE) ? -8 : -6;
    halted     = 1'b0;
    char_phase = '0;
  endfunction

  function automatic void predict_beat(input logic [7:0] c, input logic eom);
    codec_beat_t made[4];
    int n;
    int held;
    int v;
    n = 0;
    if (direction == DIR_ENCODE) begin
      bit_store = {bit_store[7:0], c};
      held = spare_bits + 14;
      while (held >= 6) begin
        made[n] = '{symbol(6'(bit_store >> (held - 6))), 1'b1, 1'b0};
        n++;
        held -= 6;
        char_phase++;
      end
      spare_bits = held - 6;
      if (eom) begin
        if (held > 0) begin
          made[n] = '{symbol(6'(bit_store << (6 - held))), 1'b1, 1'b0};
          n++;
          char_phase++;
        end
        while (char_phase != 0 && n < 4) begin
          made[n] = '{PAD_CHAR, 1'b1, 1'b0};
          n++;
          char_phase++;
        end
      end
    end else begin
      if (!halted) begin
        if (c == PAD_CHAR) begin
          halted = 1'b1;
        end else begin
          v = sextet_of(c);
          if (v < 64) begin
            bit_store = {bit_store[9:0], 6'(v)};
            spare_bits += 6;
            if (spare_bits >= 0) begin
              made[n] = '{8'(bit_store >> spare_bits), 1'b1, 1'b0};
              n++;
              spare_bits -= 8;
            end
          end
        end
      end
      // bare end marker
      if (eom && n == 0) begin
        made[n] = '{8'h00, 1'b0, 1'b0};
        n++;
      end
    end
    if (eom) begin
      made[n - 1].fin = 1'b1;
      idle_state();
    end
    for (int i = 0; i < n; i++) owed_beats = {owed_beats, made[i]};
  endfunction

  always @(posedge clk) begin
    codec_beat_t want;
    codec_beat_t got;
    if (rst) begin
      direction = DIR_ENCODE;
      idle_state();
      owed_beats.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        got = '{dout.data_out, dout.data_present, dout.final_res};
        if (owed_beats.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected beat data=%h present=%b fin=%b",
                     $realtime, got.data, got.present, got.fin);
        end else begin
          want = owed_beats.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: beat mismatch exp data=%h present=%b fin=%b, got data=%h present=%b fin=%b",
                       $realtime, want.data, want.present, want.fin,
                       got.data, got.present, got.fin);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        direction = cfg.data;
        idle_state();
      end
      if (din.valid && din.ready) predict_beat(din.data_in, din.end_of_message);
    end
    results_owed <= owed_beats.size();
    mismatches   <= fail_total;
  end

endmodule

/* tb/sv/tb_top.sv */
// Base64 codec testbench top: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import b64_pkg::*;

  // Longest run of cycles with no beat moving on any channel.
  localparam int unsigned STALL_LIMIT = 2000;
  // A result passes the bundle queue and output beat register once its input
  // beat is taken; leave some margin before touching the direction register.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Input beats per direction per idling phase in the random part.
  localparam int unsigned PHASE_BEATS = 40;

  logic        clk;
  logic        rst;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches;
  int unsigned results_owed;

  b64_cfg_if cfg_bus();
  b64_in_if  din_bus();
  b64_out_if dout_bus();

  base64_codec DUT (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .din  (din_bus),
    .dout (dout_bus)
  );

  b64_stream_check codec_check (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_bus),
    .din          (din_bus),
    .dout         (dout_bus),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready redrawn every cycle, stall rate set per phase.
  always @(posedge clk) begin
    dout_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat. valid is left high after the accepting edge, so the
  // caller must drive it again (next beat, idle or settle) in the same step.
  task automatic send_beat(input logic [7:0] code, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      din_bus.valid <= 1'b0;
      @(posedge clk);
    end
    din_bus.valid          <= 1'b1;
    din_bus.data_in        <= code;
    din_bus.end_of_message <= eom;
    @(posedge clk);
    while (!din_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input logic eom);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], eom && (i == s.len() - 1));
  endtask

  // Drop valid, wait for every owed result, then let the pipe go quiet.
  // results_owed is registered, hence the first wait before looking.
  task automatic settle();
    din_bus.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= dir;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random character of the Base64 alphabet.
  function automatic logic [7:0] text_char();
    case ($urandom_range(3))
      0:       return 8'h41 + 8'($urandom_range(25));   // A..Z
      1:       return 8'h61 + 8'($urandom_range(25));   // a..z
      2:       return 8'h30 + 8'($urandom_range(9));    // 0..9
      default: return $urandom_range(1) ? 8'h2B : 8'h2F; // + or /
    endcase
  endfunction

  // Encode message: mostly short, now and then a longer one.
  task automatic send_bytes_message();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
    for (int i = 0; i < len; i++) send_beat(8'($urandom_range(255)), i == len - 1);
  endtask

  // Decode message. Most are well formed: whole groups of four, the last
  // one optionally padded. The rest mix alphabet, '=' and arbitrary bytes.
  task automatic send_text_message();
    int len;
    int pad;
    int r;
    logic [7:0] code;
    if ($urandom_range(9) < 7) begin
      len = 4 * $urandom_range(2, 1);
      pad = $urandom_range(2);
      for (int i = 0; i < len; i++) begin
        code = (i >= len - pad) ? PAD_CHAR : text_char();
        send_beat(code, i == len - 1);
      end
    end else begin
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 60)      code = text_char();
        else if (r < 75) code = PAD_CHAR;
        else             code = 8'($urandom_range(255));
        send_beat(code, i == len - 1);
      end
    end
  endtask

  initial begin
    int unsigned start;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= DIR_ENCODE;
    din_bus.valid <= 1'b0;
    din_bus.data_in <= 8'h00;
    din_bus.end_of_message <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, encode by reset default.
    send_beat(8'h00, 1'b1);                      // one byte, two pad chars
    send_beat(8'hFF, 1'b0);                      // all ones, one pad char
    send_beat(8'hFF, 1'b1);
    send_beat(8'hFB, 1'b0);                      // full group of '+'
    send_beat(8'hEF, 1'b0);
    send_beat(8'hBE, 1'b1);
    send_beat(8'h41, 1'b0);                      // left open, then abandoned
    send_beat(8'h42, 1'b0);
    settle();
    write_direction(DIR_DECODE);

    // Directed decode.
    send_text("TWFu", 1'b1);                     // plain group
    send_text("TQ==A", 1'b1);                    // pad stops, later char ignored
    send_beat(8'h2A, 1'b0);                      // skipped characters
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("/+", 1'b1);
    send_text("z", 1'b1);                        // too few bits: bare end
    send_beat(8'h80, 1'b1);                      // skipped char as last: bare end
    send_text("Q", 1'b0);                        // left open, then abandoned
    settle();

    // Random part: four idling phases, both directions in each.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 57;
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct <= 30;
        end
      endcase
      write_direction(DIR_ENCODE);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) send_bytes_message();
      settle();
      write_direction(DIR_DECODE);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) send_text_message();
      settle();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
